### sv/grid_linear_interpolator_core_assert.svh
// Assertion macros used by the port-level checker.
`ifndef GRID_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define GRID_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define GLI_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GLI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

### sv/gli_pkg.sv
// Package with payload types and constants of the grid interpolator.
package gli_pkg;
    localparam int MaxPoints = 1024;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;
    localparam int WgtW = 17;
    localparam logic [WgtW-1:0] WgtOne = 17'h10000;

    localparam logic [1:0] ReqCoord = 2'd0;
    localparam logic [1:0] ReqMap = 2'd1;
    localparam logic [1:0] ReqValue = 2'd2;
    localparam logic [1:0] ReqQuery = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [IdxW-1:0] entry_index;
        logic signed [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0] target_index;
        logic signed [31:0] interpolated_value;
    } t_out_item;
endpackage

### sv/gli_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module gli_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/grid_linear_interpolator_core.sv
// Top level of the grid linear interpolator.
// Input channel (i_in_valid/o_in_ready) carries one t_in_item per transfer; results
// leave on o_out_valid/o_out_item and are taken with i_out_ready.
// Type 0 and type 2 write a source coordinate or value at the transfer edge, and
// the core is ready again in the next cycle.
// Type 1 runs a binary search over source_count coordinates (each step presents the
// address in StSrchW and compares in StSrch, through the coordinate memory port;
// eleven steps for 1024 points) and, unless the weight is clamped, a 16-step
// restoring division, then writes the neighbor entry; input is blocked until it is written.
// Type 3 reads the neighbor entry, then both source values through one value
// memory port, and does two 32x17 products in turn (StQEnt, StQLeft, StQRgt, StMul1,
// StMul2, StOut); the result shows on o_out_valid in the same cycle as the core
// is ready to take the next item.
// One item is worked on at a time. The output register holds a result while
// i_out_ready is low; the core keeps taking items, but a query that finishes
// while the previous result still waits stays in its last step and blocks input.
// Reset is synchronous and active low; it returns the control to idle and
// source_count to 1. Memories are not cleared, an entry must be written before it
// is read. i_cfg_we writes source_count at once.
module grid_linear_interpolator_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [10:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gli_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gli_pkg::t_out_item o_out_item
);
    localparam int IW = gli_pkg::IdxW;
    localparam int CW = gli_pkg::CntW;
    localparam int NW = 49;
    localparam int EW = 2 * IW + gli_pkg::WgtW;

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StSrch  = 4'd1;
    localparam logic [3:0] StSrchW = 4'd2;
    localparam logic [3:0] StLeftR = 4'd3;
    localparam logic [3:0] StLeftW = 4'd4;
    localparam logic [3:0] StDiv   = 4'd5;
    localparam logic [3:0] StQEnt  = 4'd6;
    localparam logic [3:0] StQLeft = 4'd7;
    localparam logic [3:0] StQRgt  = 4'd8;
    localparam logic [3:0] StMul1  = 4'd9;
    localparam logic [3:0] StMul2  = 4'd10;
    localparam logic [3:0] StOut   = 4'd11;
    localparam logic [3:0] StMapW  = 4'd12;

    logic [3:0] r_state;
    logic [CW-1:0] r_count;
    gli_pkg::t_in_item r_item;
    logic [CW-1:0] r_lo, r_hi, r_n;
    logic signed [32:0] r_cr, r_num, r_den;
    logic [NW-1:0] r_rem;
    logic [16:0] r_quo;
    logic [4:0] r_step;
    logic [IW-1:0] r_li, r_ri;
    logic [16:0] r_w;
    logic signed [31:0] r_vl;
    logic signed [49:0] r_acc;
    logic r_out_valid;
    gli_pkg::t_out_item r_out;

    logic c_we, v_we, e_we;
    logic [IW-1:0] c_ra, v_ra;
    logic [31:0] c_rd, v_rd;
    logic [EW-1:0] e_rd, e_wd;
    logic [IW-1:0] e_wa, e_ra;
    logic [CW-1:0] w_mid;
    logic in_fire;
    logic signed [32:0] w_x, w_c;
    logic [NW:0] w_trial;
    logic signed [49:0] w_prod;
    logic signed [17:0] w_mul;
    logic signed [31:0] w_mop;
    logic signed [49:0] w_q;

    assign o_in_ready = (r_state == StIdle);
    assign in_fire = i_in_valid && o_in_ready;
    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_x = 33'(r_item.data_word);
    assign w_c = 33'($signed(c_rd));

    always_comb begin
        c_we = in_fire && (i_in_item.req_type == gli_pkg::ReqCoord);
        v_we = in_fire && (i_in_item.req_type == gli_pkg::ReqValue);
        c_ra = w_mid[IW-1:0];
        if (r_state == StSrchW && r_lo >= r_hi) begin
            c_ra = IW'(r_lo - CW'(1));
        end
        v_ra = (r_state == StQLeft) ? e_rd[EW-1 -: IW] : e_rd[EW-IW-1 -: IW];
        if (r_state != StQEnt && r_state != StQLeft) begin
            v_ra = r_ri;
        end
        if (r_state == StQEnt) begin
            v_ra = e_rd[EW-1 -: IW];
        end
        e_we = (r_state == StMapW);
        e_wa = r_item.entry_index;
        e_wd = {r_li, r_ri, r_w};
        // The entry read starts at the transfer edge so it is ready in the next cycle.
        e_ra = in_fire ? i_in_item.entry_index : r_item.entry_index;
    end

    gli_ram #(.Width(32), .Depth(gli_pkg::MaxPoints)) u_coord (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(i_in_item.entry_index),
        .i_wdata(i_in_item.data_word), .i_raddr(c_ra), .o_rdata(c_rd));
    gli_ram #(.Width(32), .Depth(gli_pkg::MaxPoints)) u_value (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(i_in_item.entry_index),
        .i_wdata(i_in_item.data_word), .i_raddr(v_ra), .o_rdata(v_rd));
    gli_ram #(.Width(EW), .Depth(gli_pkg::MaxPoints)) u_entry (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa),
        .i_wdata(e_wd), .i_raddr(e_ra), .o_rdata(e_rd));

    assign w_trial = {r_rem, 1'b0} - {{(NW-31){1'b0}}, r_den[31:0]};
    assign w_mop = (r_state == StMul1) ? r_vl : $signed(v_rd);
    assign w_mul = (r_state == StMul1) ? $signed({1'b0, 17'(18'h10000 - {1'b0, r_w})})
                                       : $signed({1'b0, r_w});
    assign w_prod = 50'(w_mop) * 50'(w_mul);
    // Floor shift is an arithmetic shift of the sum.
    assign w_q = (r_acc + w_prod) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_count <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && r_state != StOut) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                StIdle: begin
                    if (in_fire) begin
                        r_item <= i_in_item;
                        r_n <= (r_count == '0) ? CW'(1)
                             : (r_count > CW'(gli_pkg::MaxPoints)) ? CW'(gli_pkg::MaxPoints)
                             : r_count;
                        r_lo <= '0;
                        r_hi <= (r_count == '0) ? CW'(1)
                              : (r_count > CW'(gli_pkg::MaxPoints)) ? CW'(gli_pkg::MaxPoints)
                              : r_count;
                        if (i_in_item.req_type == gli_pkg::ReqMap) begin
                            r_state <= StSrchW;
                        end else if (i_in_item.req_type == gli_pkg::ReqQuery) begin
                            r_state <= StQEnt;
                        end
                    end
                end
                StSrchW: begin
                    // Address for the next probe is presented here.
                    if (r_lo >= r_hi) begin
                        if (r_lo == '0) begin
                            r_li <= '0; r_ri <= '0; r_w <= gli_pkg::WgtOne;
                            r_state <= StMapW;
                        end else if (r_lo >= r_n) begin
                            r_li <= IW'(r_n - CW'(1)); r_ri <= IW'(r_n - CW'(1));
                            r_w <= '0;
                            r_state <= StMapW;
                        end else begin
                            r_state <= StLeftR;
                        end
                    end else begin
                        r_state <= StSrch;
                    end
                end
                StSrch: begin
                    if (w_c < w_x) begin
                        r_lo <= w_mid + CW'(1);
                    end else begin
                        r_hi <= w_mid;
                        r_cr <= w_c;
                    end
                    r_state <= StSrchW;
                end
                StLeftR: begin
                    r_li <= IW'(r_lo - CW'(1));
                    r_ri <= r_lo[IW-1:0];
                    r_num <= w_x - w_c;
                    r_den <= r_cr - w_c;
                    r_state <= StLeftW;
                end
                StLeftW: begin
                    if (r_num <= 0) begin
                        r_w <= '0;
                        r_state <= StMapW;
                    end else if (r_num >= r_den) begin
                        r_w <= gli_pkg::WgtOne;
                        r_state <= StMapW;
                    end else begin
                        r_rem <= NW'(r_num[31:0]);
                        r_quo <= '0;
                        r_step <= '0;
                        r_state <= StDiv;
                    end
                end
                StDiv: begin
                    // Restoring division, one quotient bit per cycle.
                    if (!w_trial[NW]) begin
                        r_rem <= w_trial[NW-1:0];
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[NW-2:0], 1'b0};
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd15) begin
                        r_state <= StMapW;
                        r_w <= {1'b0, r_quo[14:0], !w_trial[NW]};
                    end
                end
                StMapW: begin
                    if (r_step == 5'd16) begin
                        r_step <= '0;
                    end
                    r_state <= StIdle;
                end
                StQEnt: begin
                    r_li <= e_rd[EW-1 -: IW];
                    r_ri <= e_rd[EW-IW-1 -: IW];
                    r_w <= (e_rd[16:0] > gli_pkg::WgtOne) ? gli_pkg::WgtOne : e_rd[16:0];
                    r_state <= StQLeft;
                end
                StQLeft: begin
                    r_state <= StQRgt;
                end
                StQRgt: begin
                    r_vl <= $signed(v_rd);
                    r_acc <= '0;
                    r_state <= StMul1;
                end
                StMul1: begin
                    r_acc <= w_prod;
                    r_state <= StMul2;
                end
                StMul2: begin
                    r_acc <= w_q;
                    r_state <= StOut;
                end
                StOut: begin
                    // Wait here while the previous result is still held.
                    if (!r_out_valid || i_out_ready) begin
                        r_out.target_index <= r_item.entry_index;
                        r_out.interpolated_value <=
                            (r_acc > 50'sd2147483647) ? 32'sh7fffffff
                          : (r_acc < -50'sd2147483648) ? 32'sh80000000
                          : r_acc[31:0];
                        r_out_valid <= 1'b1;
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;
endmodule

### sv/gli_checker.sv
// Port-level checker for the grid interpolator, bound to the top level.
`include "grid_linear_interpolator_core_assert.svh"
module gli_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input gli_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gli_pkg::t_out_item o_out_item
);
    `GLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_item))
    `GLI_ASSERT_NEXT(a_busy_after_map, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_in_item.req_type == gli_pkg::ReqMap, !o_in_ready)
    `GLI_ASSERT_NEXT(a_busy_after_query, i_clk, i_rst_n,
        i_in_valid && o_in_ready && i_in_item.req_type == gli_pkg::ReqQuery, !o_in_ready)
    `GLI_ASSERT_NEXT(a_ready_after_store, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_in_item.req_type == gli_pkg::ReqCoord
        || i_in_item.req_type == gli_pkg::ReqValue), o_in_ready)
endmodule

bind grid_linear_interpolator_core gli_checker u_gli_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .i_in_item(i_in_item), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_item(o_out_item));
